// ----- sv/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helpers of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 16;
  localparam int unsigned MAX_RES = 3;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 16'hFFFD;
  localparam logic [CP_W-1:0] END_CP         = 16'h0000;

  // kind of multi-byte sequence in progress
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_FOUR  = 2'd3
  } kind_t;

  typedef logic [CP_W-1:0] cp_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]               cnt;
    logic                     is_end;
    logic [MAX_RES-1:0][CP_W-1:0] cp;
  } group_t;

  function automatic kind_t lead_kind(input logic [BYTE_W-1:0] b);
    kind_t k;
    k = KIND_NONE;
    priority if (!b[7])            k = KIND_NONE;
    else if (b[7:5] == 3'b110)     k = KIND_TWO;
    else if (b[7:4] == 4'b1110)    k = KIND_THREE;
    else if (b[7:3] == 5'b11110)   k = KIND_FOUR;
    else                           k = KIND_NONE;
    return k;
  endfunction

endpackage

// ----- sv/utf8d_ifs.sv -----
// ----------------------------------------------------------------------------
// utf8d_ifs
// Valid/ready channels for encoded bytes in and code points out.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::BYTE_W-1:0]  byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

interface utf8d_cp_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::CP_W-1:0]  code_point;
  logic                        end_of_text;
  logic                        last;

  modport source (output valid, output code_point, output end_of_text, output last,
                  input ready);
  modport sink   (input valid, input code_point, input end_of_text, input last,
                  output ready);
endinterface

// ----- sv/utf8d_decode.sv -----
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode into a group of up to three results.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
  output utf8d_pkg::group_t             grp
);

  utf8d_pkg::kind_t                 kind_r, kind_nxt;
  logic [1:0]                       taken_r, taken_nxt;
  logic [utf8d_pkg::BYTE_W-1:0]     lead_r, lead_nxt;
  logic [utf8d_pkg::BYTE_W-1:0]     ffb_r, ffb_nxt;
  utf8d_pkg::kind_t                 new_kind;
  logic                             is_term;
  logic [1:0]                       taken_inc;

  assign new_kind  = utf8d_pkg::lead_kind(byte_in);
  assign is_term   = (byte_in == '0);
  assign taken_inc = taken_r + 2'd1;

  // next state
  always_comb begin
    kind_nxt  = kind_r;
    taken_nxt = taken_r;
    lead_nxt  = lead_r;
    ffb_nxt   = ffb_r;
    if (is_term) begin
      kind_nxt  = utf8d_pkg::KIND_NONE;
      taken_nxt = '0;
      lead_nxt  = '0;
      ffb_nxt   = '0;
    end else begin
      unique case (kind_r)
        utf8d_pkg::KIND_TWO: begin
          kind_nxt  = utf8d_pkg::KIND_NONE;
          taken_nxt = '0;
          lead_nxt  = '0;
          ffb_nxt   = '0;
        end
        utf8d_pkg::KIND_THREE: begin
          if (taken_r == 2'd0) begin
            ffb_nxt   = byte_in;
            taken_nxt = 2'd1;
          end else begin
            kind_nxt  = utf8d_pkg::KIND_NONE;
            taken_nxt = '0;
            lead_nxt  = '0;
            ffb_nxt   = '0;
          end
        end
        utf8d_pkg::KIND_FOUR: begin
          taken_nxt = taken_inc;
          if (taken_inc == 2'd3) begin
            kind_nxt  = utf8d_pkg::KIND_NONE;
            taken_nxt = '0;
            lead_nxt  = '0;
            ffb_nxt   = '0;
          end
        end
        default: begin
          if (new_kind != utf8d_pkg::KIND_NONE) begin
            kind_nxt  = new_kind;
            taken_nxt = '0;
            lead_nxt  = byte_in;
            ffb_nxt   = '0;
          end
        end
      endcase
    end
  end

  // result group
  always_comb begin
    grp        = '0;
    grp.is_end = is_term;
    if (is_term) begin
      unique case (kind_r)
        utf8d_pkg::KIND_TWO: begin
          grp.cp[0] = {8'h00, lead_r};
          grp.cp[1] = utf8d_pkg::END_CP;
          grp.cnt   = 2'd2;
        end
        utf8d_pkg::KIND_THREE: begin
          grp.cp[0] = {8'h00, lead_r};
          if (taken_r == 2'd1) begin
            // a stray 4-byte lead in the follow slot becomes a replacement
            grp.cp[1] = (ffb_r[7:3] == 5'b11110) ? utf8d_pkg::REPLACEMENT_CP
                                                 : {8'h00, ffb_r};
            grp.cp[2] = utf8d_pkg::END_CP;
            grp.cnt   = 2'd3;
          end else begin
            grp.cp[1] = utf8d_pkg::END_CP;
            grp.cnt   = 2'd2;
          end
        end
        utf8d_pkg::KIND_FOUR: begin
          grp.cp[0] = utf8d_pkg::REPLACEMENT_CP;
          grp.cp[1] = utf8d_pkg::END_CP;
          grp.cnt   = 2'd2;
        end
        default: begin
          grp.cp[0] = utf8d_pkg::END_CP;
          grp.cnt   = 2'd1;
        end
      endcase
    end else begin
      unique case (kind_r)
        utf8d_pkg::KIND_TWO: begin
          grp.cp[0] = {5'b00000, lead_r[4:0], byte_in[5:0]};
          grp.cnt   = 2'd1;
        end
        utf8d_pkg::KIND_THREE: begin
          grp.cp[0] = {lead_r[3:0], ffb_r[5:0], byte_in[5:0]};
          grp.cnt   = (taken_r == 2'd0) ? 2'd0 : 2'd1;
        end
        utf8d_pkg::KIND_FOUR: begin
          grp.cp[0] = utf8d_pkg::REPLACEMENT_CP;
          grp.cnt   = (taken_inc == 2'd3) ? 2'd1 : 2'd0;
        end
        default: begin
          grp.cp[0] = {8'h00, byte_in};
          grp.cnt   = (new_kind == utf8d_pkg::KIND_NONE) ? 2'd1 : 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= utf8d_pkg::KIND_NONE;
      taken_r <= '0;
      lead_r  <= '0;
      ffb_r   <= '0;
    end else if (take) begin
      kind_r  <= kind_nxt;
      taken_r <= taken_nxt;
      lead_r  <= lead_nxt;
      ffb_r   <= ffb_nxt;
    end
  end

endmodule

// ----- sv/utf8d_outq.sv -----
// ----------------------------------------------------------------------------
// utf8d_outq
// Result register holding one group; hands out its entries one per transfer.
// ----------------------------------------------------------------------------
module utf8d_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  utf8d_pkg::group_t  grp,
  output logic               can_load,
  utf8d_cp_if.source         out_bus
);

  logic                    valid_r;
  logic [1:0]              idx_r;
  logic [1:0]              cnt_r;
  logic                    end_r;
  logic [utf8d_pkg::MAX_RES-1:0][utf8d_pkg::CP_W-1:0] cp_r;
  logic                    xfer;
  logic                    at_last;
  logic                    done;

  assign xfer     = out_bus.valid && out_bus.ready;
  assign at_last  = (idx_r == (cnt_r - 2'd1));
  assign done     = xfer && at_last;
  assign can_load = !valid_r || done;

  assign out_bus.valid       = valid_r;
  assign out_bus.code_point  = cp_r[idx_r];
  assign out_bus.last        = at_last;
  assign out_bus.end_of_text = end_r && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (done) begin
        valid_r <= 1'b0;
      end else if (xfer) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load && (grp.cnt != 2'd0)) begin
        valid_r <= 1'b1;
        idx_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && (grp.cnt != 2'd0)) begin
      cnt_r <= grp.cnt;
      end_r <= grp.is_end;
      cp_r  <= grp.cp;
    end
  end

endmodule

// ----- sv/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a zero-terminated UTF-8 byte stream into 16-bit code points.
// ----------------------------------------------------------------------------
// a byte waits in the input register until the result register takes its group
// throughput: one byte per cycle while the result register can load; a byte with
//   n results holds it for n transfers, and up to 3 for a terminator mid-sequence
// reset: synchronous active-low rst_n clears all sequence state and empties
//   the input and result registers
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_byte_if.sink  in_bus,
  utf8d_cp_if.source  out_bus
);

  logic                          in_valid_r;
  logic [utf8d_pkg::BYTE_W-1:0]  byte_r;
  logic                          can_load;
  logic                          take;
  utf8d_pkg::group_t             grp;

  // decode the held byte once the result register can take its group
  assign take         = in_valid_r && can_load;
  assign in_bus.ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      byte_r <= in_bus.byte_value;
    end
  end

  utf8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (byte_r),
    .grp     (grp)
  );

  utf8d_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .grp      (grp),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

endmodule

// ----- tb/utf8_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Feeds zero-terminated byte streams into the decoder: hand-picked sequences
// first, then random text built mostly from well-formed multi-byte sequences
// mixed with stray bytes, truncated sequences and noise. A behavioral decoder
// in the bench predicts every code point, and each result transfer is checked
// field by field against the oldest prediction. Both channels idle at random in
// some phases, and one holds the result channel off while bytes keep coming.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

  localparam int HOLD_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    utf8d_pkg::cp_t  cp;
    logic            eot;
    logic            last;
  } cp_item_t;

  logic clk;
  logic rst_n;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_stream_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_ch),
    .out_bus (cp_ch)
  );

  // decoder state mirrored by the bench
  utf8d_pkg::kind_t  seq_kind;
  logic [1:0]        seq_taken;
  logic [7:0]        seq_lead;
  logic [7:0]        seq_follow;

  cp_item_t expected_cps[$];

  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int hold_left;
  int stall_left;
  int error_count;
  int bytes_sent;
  int cps_checked;
  int ends_seen;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_decoder();
    seq_kind   = utf8d_pkg::KIND_NONE;
    seq_taken  = 2'd0;
    seq_lead   = 8'h00;
    seq_follow = 8'h00;
  endfunction

  // works out the code points one accepted byte gives and queues them
  task automatic decode_byte(input logic [7:0] value);
    cp_item_t        res[$];
    utf8d_pkg::cp_t  flushed;
    if (value == 8'h00) begin
      if (seq_kind == utf8d_pkg::KIND_TWO || seq_kind == utf8d_pkg::KIND_THREE) begin
        res.push_back(cp_item_t'{{8'h00, seq_lead}, 1'b0, 1'b0});
        if (seq_kind == utf8d_pkg::KIND_THREE && seq_taken == 2'd1) begin
          flushed = (seq_follow[7:3] == 5'b11110) ? utf8d_pkg::REPLACEMENT_CP
                                                  : {8'h00, seq_follow};
          res.push_back(cp_item_t'{flushed, 1'b0, 1'b0});
        end
      end else if (seq_kind == utf8d_pkg::KIND_FOUR) begin
        res.push_back(cp_item_t'{utf8d_pkg::REPLACEMENT_CP, 1'b0, 1'b0});
      end
      res.push_back(cp_item_t'{utf8d_pkg::END_CP, 1'b1, 1'b0});
      clear_decoder();
    end else begin
      case (seq_kind)
        utf8d_pkg::KIND_TWO: begin
          res.push_back(cp_item_t'{{5'b0, seq_lead[4:0], value[5:0]}, 1'b0, 1'b0});
          clear_decoder();
        end
        utf8d_pkg::KIND_THREE: begin
          if (seq_taken == 2'd0) begin
            seq_follow = value;
            seq_taken  = 2'd1;
          end else begin
            res.push_back(cp_item_t'{{seq_lead[3:0], seq_follow[5:0], value[5:0]},
                                     1'b0, 1'b0});
            clear_decoder();
          end
        end
        utf8d_pkg::KIND_FOUR: begin
          seq_taken = seq_taken + 2'd1;
          if (seq_taken == 2'd3) begin
            res.push_back(cp_item_t'{utf8d_pkg::REPLACEMENT_CP, 1'b0, 1'b0});
            clear_decoder();
          end
        end
        default: begin
          casez (value)
            8'b110?????: seq_kind = utf8d_pkg::KIND_TWO;
            8'b1110????: seq_kind = utf8d_pkg::KIND_THREE;
            8'b11110???: seq_kind = utf8d_pkg::KIND_FOUR;
            default:     seq_kind = utf8d_pkg::KIND_NONE;
          endcase
          if (seq_kind == utf8d_pkg::KIND_NONE) begin
            res.push_back(cp_item_t'{{8'h00, value}, 1'b0, 1'b0});
          end else begin
            seq_taken  = 2'd0;
            seq_lead   = value;
            seq_follow = 8'h00;
          end
        end
      endcase
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_cps.push_back(res[i]);
  endtask

  // valid stays high from one transfer to the next unless a gap is drawn
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_value <= value;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(value);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_follow();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] rand_lead(input utf8d_pkg::kind_t k);
    case (k)
      utf8d_pkg::KIND_TWO:   return 8'($urandom_range(8'hC0, 8'hDF));
      utf8d_pkg::KIND_THREE: return 8'($urandom_range(8'hE0, 8'hEF));
      default:               return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // one chunk of random text; mostly complete sequences with random payload
  task automatic send_random_chunk(output int count);
    logic [7:0]        chunk[$];
    utf8d_pkg::kind_t  k;
    int                pick;
    int                need;
    int                keep;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      chunk.push_back(8'($urandom_range(1, 127)));
    end else if (pick < 75) begin
      k    = (pick < 45) ? utf8d_pkg::KIND_TWO :
             (pick < 65) ? utf8d_pkg::KIND_THREE : utf8d_pkg::KIND_FOUR;
      need = int'(k);
      chunk.push_back(rand_lead(k));
      repeat (need) chunk.push_back(rand_follow());
    end else if (pick < 82) begin
      chunk.push_back(8'h00);
    end else if (pick < 90) begin
      // truncated sequence cut off by the terminator
      k    = utf8d_pkg::kind_t'($urandom_range(1, 3));
      need = int'(k);
      keep = $urandom_range(0, need - 1);
      chunk.push_back(rand_lead(k));
      repeat (keep) begin
        if (k == utf8d_pkg::KIND_THREE && $urandom_range(0, 1) == 1)
          chunk.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        else
          chunk.push_back(rand_follow());
      end
      chunk.push_back(8'h00);
    end else begin
      chunk.push_back(8'($urandom_range(0, 255)));
    end
    foreach (chunk[i]) send_byte(chunk[i]);
    count = chunk.size();
  endtask

  task automatic send_random_text(input int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      send_random_chunk(n);
      sent += n;
    end
  endtask

  task automatic test_directed_cases();
    logic [7:0] stream[$];
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    stream = '{8'h01, 8'h7F,
               8'hC3, 8'hA9,                     // two-byte character
               8'hE2, 8'h82, 8'hAC,              // three-byte character
               8'hF0, 8'h9F, 8'h98, 8'h80,       // four-byte lead gives replacement
               8'h80, 8'hBF, 8'hF8, 8'hFF,       // stray bytes pass raw
               8'h00,                            // terminator, nothing pending
               8'hDF, 8'h00,                     // two-byte lead cut off
               8'hEF, 8'hF3, 8'h00,              // follow of form 11110xxx flushed
               8'hE0, 8'hFF, 8'h00,              // raw follow flushed
               8'hF7, 8'h9F, 8'h00};             // four-byte lead cut off
    foreach (stream[i]) send_byte(stream[i]);
  endtask

  task automatic test_random_text(input int target);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_random_text(target);
  endtask

  task automatic test_back_to_back(input int target);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random_text(target);
  endtask

  // result side held off while bytes keep coming, so the input backs up
  task automatic test_output_stall(input int target);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    while (hold_left == 0) @(posedge clk);
    send_random_text(target);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cp_ch.ready <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (cp_ch.valid && cp_ch.ready) stall_left = rx_idle ? $urandom_range(0, 16) : 0;
      if (hold_left > 0) begin
        hold_left--;
        cp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cp_ch.ready <= 1'b0;
      end else begin
        cp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    cp_item_t want;
    if (rst_n && cp_ch.valid && cp_ch.ready) begin
      cps_checked++;
      if (expected_cps.size() == 0) begin
        report_error($sformatf("unexpected code point %h eot %b last %b",
                               cp_ch.code_point, cp_ch.end_of_text, cp_ch.last));
      end else begin
        want = expected_cps.pop_front();
        if (cp_ch.code_point !== want.cp)
          report_error($sformatf("code_point %h, expected %h", cp_ch.code_point, want.cp));
        if (cp_ch.end_of_text !== want.eot)
          report_error($sformatf("end_of_text %b, expected %b on cp %h",
                                 cp_ch.end_of_text, want.eot, want.cp));
        if (cp_ch.last !== want.last)
          report_error($sformatf("last %b, expected %b on cp %h",
                                 cp_ch.last, want.last, want.cp));
        if (want.eot) ends_seen++;
      end
    end
  end

  // counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_cps.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    byte_ch.valid      <= 1'b0;
    byte_ch.byte_value <= 8'h00;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    hold_req    = 1'b0;
    error_count = 0;
    bytes_sent  = 0;
    cps_checked = 0;
    ends_seen   = 0;
    idle_cycles = 0;
    clear_decoder();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_text(140);
    test_back_to_back(50);
    test_output_stall(40);
    test_random_text(70);

    byte_ch.valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d code points across %0d strings",
             bytes_sent, cps_checked, ends_seen);
    $display("covered random idling, back-to-back traffic and a held-off result channel");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/utf8d_pkg.sv
sv/utf8d_ifs.sv
sv/utf8d_decode.sv
sv/utf8d_outq.sv
sv/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
